>>> hdl/tbh_pkg.sv
`default_nettype none

package tbh_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int DUTY_W      = 8;
	localparam int SCALED_W    = SAMPLE_W + DUTY_W;
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 16;

	localparam int LEARN_SAMPLES_DEF = 256;
	localparam int DUTY_SPAN_DEF     = 10000;

	localparam logic [CFG_INDEX_W-1:0] REG_TOUCH_ON  = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_TOUCH_OFF = CFG_INDEX_W'(1);

	localparam logic [SAMPLE_W-1:0] TOUCH_ON_RST  = SAMPLE_W'(3000);
	localparam logic [SAMPLE_W-1:0] TOUCH_OFF_RST = SAMPLE_W'(1500);

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_TICK   = 1'b1;

	// item leaving the learn / baseline divide stages
	typedef struct packed {
		logic                kind;
		logic [SAMPLE_W-1:0] raw;
		logic                lock_now;
		logic                locked;
		logic [SAMPLE_W-1:0] quot;
	} learn_item_t;

	// item leaving the delta / hysteresis stage
	typedef struct packed {
		logic                kind;
		logic                locked;
		logic [SAMPLE_W-1:0] baseline;
		logic [SAMPLE_W-1:0] mag;
		logic                neg;
		logic                touched;
		logic [SCALED_W-1:0] scaled;
	} delta_item_t;

endpackage

`default_nettype wire

>>> hdl/tbh_const_div.sv
`default_nettype none

module tbh_const_div #(
	parameter int DIVISOR    = 3,
	parameter int DIVIDEND_W = 16,
	parameter int QUOT_W     = 16
) (
	input  wire logic [DIVIDEND_W-1:0] dividend,
	output logic      [QUOT_W-1:0]     quotient
);

	// reciprocal multiply, exact for every dividend below 2**DIVIDEND_W
	localparam int DIV_LOG = $clog2(DIVISOR);
	localparam int SHIFT   = DIVIDEND_W + DIV_LOG;
	localparam int RECIP_W = DIVIDEND_W + 1;
	localparam int PROD_W  = DIVIDEND_W + RECIP_W;
	localparam logic [63:0] RECIP =
		((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

	logic [PROD_W-1:0] prod;

	assign prod     = PROD_W'(dividend) * PROD_W'(RECIP[RECIP_W-1:0]);
	assign quotient = prod[SHIFT +: QUOT_W];

endmodule

`default_nettype wire

>>> hdl/tbh_learn.sv
`default_nettype none

module tbh_learn
	import tbh_pkg::*;
#(
	parameter int LEARN_SAMPLES = LEARN_SAMPLES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_ready,
	input  wire logic                kind,
	input  wire logic [SAMPLE_W-1:0] raw_sample,
	input  wire logic                scanner_initialising,
	output logic                     valid_s2,
	output learn_item_t              item_s2,
	input  wire logic                take_s3
);

	localparam int SUM_W = SAMPLE_W + $clog2(LEARN_SAMPLES);
	localparam int CNT_W = $clog2(LEARN_SAMPLES + 1);

	logic [SUM_W-1:0]    learn_sum_q;
	logic [CNT_W-1:0]    learn_count_q;
	logic                locked_q;

	logic                valid_s1;
	logic                kind_s1;
	logic [SAMPLE_W-1:0] raw_s1;
	logic                lock_now_s1;
	logic                locked_s1;
	logic [SUM_W-1:0]    sum_s1;

	logic                take_s1;
	logic                take_s2;
	logic                fire;
	logic                learn_en;
	logic                lock_now;
	logic [SUM_W-1:0]    sum_next;
	logic [SAMPLE_W-1:0] quot;

	assign take_s2    = !valid_s2 || take_s3;
	assign take_s1    = !valid_s1 || take_s2;
	assign item_ready = take_s1;
	assign fire       = item_valid && take_s1;

	assign learn_en = (kind == KIND_SAMPLE) && !locked_q && !scanner_initialising;
	assign sum_next = learn_sum_q + SUM_W'(raw_sample);
	assign lock_now = learn_en && (learn_count_q == CNT_W'(LEARN_SAMPLES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learn_sum_q   <= '0;
			learn_count_q <= '0;
			locked_q      <= 1'b0;
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
		end else begin
			if (fire && learn_en) begin
				learn_sum_q   <= sum_next;
				learn_count_q <= learn_count_q + CNT_W'(1);
				if (lock_now) begin
					locked_q <= 1'b1;
				end
			end
			if (take_s1) begin
				valid_s1 <= item_valid;
			end
			if (take_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			kind_s1     <= kind;
			raw_s1      <= raw_sample;
			lock_now_s1 <= lock_now;
			locked_s1   <= locked_q || lock_now;
			sum_s1      <= sum_next;
		end
	end

	// truncated average of the learned readings
	tbh_const_div #(
		.DIVISOR    (LEARN_SAMPLES),
		.DIVIDEND_W (SUM_W),
		.QUOT_W     (SAMPLE_W)
	) u_avg_div (
		.dividend (sum_s1),
		.quotient (quot)
	);

	always_ff @(posedge clk) begin
		if (take_s2) begin
			item_s2.kind     <= kind_s1;
			item_s2.raw      <= raw_s1;
			item_s2.lock_now <= lock_now_s1;
			item_s2.locked   <= locked_s1;
			item_s2.quot     <= quot;
		end
	end

endmodule

`default_nettype wire

>>> hdl/tbh_delta.sv
`default_nettype none

module tbh_delta
	import tbh_pkg::*;
#(
	parameter int DUTY_SPAN = DUTY_SPAN_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_write_en,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   valid_s2,
	input  wire learn_item_t            item_s2,
	output logic                        take_s3,
	output logic                        valid_s3,
	output delta_item_t                 item_s3,
	input  wire logic                   take_out
);

	logic [SAMPLE_W-1:0] touch_on_q;
	logic [SAMPLE_W-1:0] touch_off_q;
	logic [SAMPLE_W-1:0] baseline_q;
	logic                touch_q;

	logic                fire;
	logic                active;
	logic [SAMPLE_W-1:0] base;
	logic [SAMPLE_W-1:0] mag;
	logic                neg;
	logic [SAMPLE_W-1:0] pos;
	logic                touch_next;
	logic [SCALED_W-1:0] scaled;

	assign take_s3 = !valid_s3 || take_out;
	assign fire    = valid_s2 && take_s3;

	assign base   = item_s2.lock_now ? item_s2.quot : baseline_q;
	assign active = (item_s2.kind == KIND_SAMPLE) && item_s2.locked;

	always_comb begin
		mag = '0;
		neg = 1'b0;
		if (active) begin
			if (item_s2.raw >= base) begin
				mag = item_s2.raw - base;
			end else begin
				mag = base - item_s2.raw;
				neg = 1'b1;
			end
		end
	end

	always_comb begin
		touch_next = touch_q;
		if (active) begin
			if (!touch_q && !neg && (mag >= touch_on_q)) begin
				touch_next = 1'b1;
			end else if (touch_q && (neg || (mag < touch_off_q))) begin
				touch_next = 1'b0;
			end
		end
	end

	// clamp positive delta, zero before lock or below baseline
	always_comb begin
		pos = '0;
		if (active && !neg) begin
			pos = (mag > SAMPLE_W'(DUTY_SPAN)) ? SAMPLE_W'(DUTY_SPAN) : mag;
		end
	end

	// pos * 255
	assign scaled = (SCALED_W'(pos) << DUTY_W) - SCALED_W'(pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touch_on_q  <= TOUCH_ON_RST;
			touch_off_q <= TOUCH_OFF_RST;
			baseline_q  <= '0;
			touch_q     <= 1'b0;
			valid_s3    <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					REG_TOUCH_ON:  touch_on_q  <= cfg_data[SAMPLE_W-1:0];
					REG_TOUCH_OFF: touch_off_q <= cfg_data[SAMPLE_W-1:0];
					default: ;
				endcase
			end
			if (fire) begin
				touch_q <= touch_next;
				if (item_s2.lock_now) begin
					baseline_q <= item_s2.quot;
				end
			end
			if (take_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s3) begin
			item_s3.kind     <= item_s2.kind;
			item_s3.locked   <= item_s2.locked;
			item_s3.baseline <= base;
			item_s3.mag      <= mag;
			item_s3.neg      <= neg;
			item_s3.touched  <= touch_next;
			item_s3.scaled   <= scaled;
		end
	end

endmodule

`default_nettype wire

>>> hdl/tbh_pwm.sv
`default_nettype none

module tbh_pwm
	import tbh_pkg::*;
#(
	parameter int DUTY_SPAN = DUTY_SPAN_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                valid_s3,
	input  wire delta_item_t         item_s3,
	output logic                     take_out,
	output logic                     result_valid,
	input  wire logic                result_ready,
	output logic                     led_on,
	output logic [DUTY_W-1:0]        duty,
	output logic                     touched,
	output logic [SAMPLE_W-1:0]      delta_magnitude,
	output logic                     delta_negative,
	output logic                     baseline_locked,
	output logic [SAMPLE_W-1:0]      baseline_value
);

	logic [DUTY_W-1:0]   duty_q;
	logic [DUTY_W-1:0]   phase_q;
	logic                led_q;
	logic                result_valid_q;

	logic                led_on_q;
	logic [DUTY_W-1:0]   duty_out_q;
	logic                touched_q;
	logic [SAMPLE_W-1:0] mag_q;
	logic                neg_q;
	logic                locked_q;
	logic [SAMPLE_W-1:0] baseline_out_q;

	logic                fire;
	logic                is_tick;
	logic [DUTY_W-1:0]   duty_calc;
	logic [DUTY_W-1:0]   duty_next;
	logic [DUTY_W-1:0]   phase_next;
	logic                led_next;
	logic                led_now;

	assign take_out = !result_valid_q || result_ready;
	assign fire     = valid_s3 && take_out;
	assign is_tick  = (item_s3.kind == KIND_TICK);

	tbh_const_div #(
		.DIVISOR    (DUTY_SPAN),
		.DIVIDEND_W (SCALED_W),
		.QUOT_W     (DUTY_W)
	) u_duty_div (
		.dividend (item_s3.scaled),
		.quotient (duty_calc)
	);

	assign phase_next = phase_q + DUTY_W'(1);
	assign led_next   = phase_next < duty_q;
	assign duty_next  = is_tick ? duty_q : duty_calc;
	assign led_now    = is_tick ? led_next : led_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q         <= '0;
			phase_q        <= '0;
			led_q          <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				if (is_tick) begin
					phase_q <= phase_next;
					led_q   <= led_next;
				end else begin
					duty_q <= duty_calc;
				end
			end
			if (take_out) begin
				result_valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_out) begin
			led_on_q       <= led_now;
			duty_out_q     <= duty_next;
			touched_q      <= item_s3.touched;
			mag_q          <= item_s3.mag;
			neg_q          <= item_s3.neg;
			locked_q       <= item_s3.locked;
			baseline_out_q <= item_s3.baseline;
		end
	end

	assign result_valid    = result_valid_q;
	assign led_on          = led_on_q;
	assign duty            = duty_out_q;
	assign touched         = touched_q;
	assign delta_magnitude = mag_q;
	assign delta_negative  = neg_q;
	assign baseline_locked = locked_q;
	assign baseline_value  = baseline_out_q;

endmodule

`default_nettype wire

>>> hdl/touch_baseline_hysteresis_pwm_top.sv
// an accepted item beat moves through s1, s2 and s3 to the result register;
// one item per cycle while result_ready is high; stages, each a register stage,
// are accumulate, baseline divide, delta and hysteresis, duty scale and pwm
// reset: asynchronous, clears learn state, baseline, touch, duty, pwm phase,
// led and all valids; thresholds return to 3000 and 1500
`default_nettype none

module touch_baseline_hysteresis_pwm_top
	import tbh_pkg::*;
#(
	parameter int LEARN_SAMPLES = LEARN_SAMPLES_DEF,
	parameter int DUTY_SPAN     = DUTY_SPAN_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_write_en,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   item_valid,
	output logic                        item_ready,
	input  wire logic                   kind,
	input  wire logic [SAMPLE_W-1:0]    raw_sample,
	input  wire logic                   scanner_initialising,
	output logic                        result_valid,
	input  wire logic                   result_ready,
	output logic                        led_on,
	output logic [DUTY_W-1:0]           duty,
	output logic                        touched,
	output logic [SAMPLE_W-1:0]         delta_magnitude,
	output logic                        delta_negative,
	output logic                        baseline_locked,
	output logic [SAMPLE_W-1:0]         baseline_value
);

	logic        valid_s2;
	learn_item_t item_s2;
	logic        take_s3;
	logic        valid_s3;
	delta_item_t item_s3;
	logic        take_out;

	tbh_learn #(
		.LEARN_SAMPLES (LEARN_SAMPLES)
	) u_learn (
		.clk                  (clk),
		.arst_n               (arst_n),
		.item_valid           (item_valid),
		.item_ready           (item_ready),
		.kind                 (kind),
		.raw_sample           (raw_sample),
		.scanner_initialising (scanner_initialising),
		.valid_s2             (valid_s2),
		.item_s2              (item_s2),
		.take_s3              (take_s3)
	);

	tbh_delta #(
		.DUTY_SPAN (DUTY_SPAN)
	) u_delta (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.valid_s2     (valid_s2),
		.item_s2      (item_s2),
		.take_s3      (take_s3),
		.valid_s3     (valid_s3),
		.item_s3      (item_s3),
		.take_out     (take_out)
	);

	tbh_pwm #(
		.DUTY_SPAN (DUTY_SPAN)
	) u_pwm (
		.clk             (clk),
		.arst_n          (arst_n),
		.valid_s3        (valid_s3),
		.item_s3         (item_s3),
		.take_out        (take_out),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.led_on          (led_on),
		.duty            (duty),
		.touched         (touched),
		.delta_magnitude (delta_magnitude),
		.delta_negative  (delta_negative),
		.baseline_locked (baseline_locked),
		.baseline_value  (baseline_value)
	);

endmodule

`default_nettype wire

>>> bench/touch_baseline_hysteresis_pwm_top_tb.sv
module touch_baseline_hysteresis_pwm_top_tb;
	import tbh_pkg::*;

	localparam int PIPE_LATENCY   = 4;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_AT        = 300;
	localparam int HOLD_CYCLES    = 64;
	localparam int REPORT_LIMIT   = 10;
	localparam int PHASE_ITEMS    = 40;

	localparam logic [CFG_INDEX_W-1:0] REG_PAST_END  = CFG_INDEX_W'(2);
	localparam logic [CFG_INDEX_W-1:0] REG_INDEX_TOP = '1;

	typedef struct packed {
		logic                kind;
		logic [SAMPLE_W-1:0] raw;
		logic                init;
	} sense_beat_t;

	typedef struct packed {
		logic                led;
		logic [DUTY_W-1:0]   duty;
		logic                touched;
		logic [SAMPLE_W-1:0] mag;
		logic                neg;
		logic                locked;
		logic [SAMPLE_W-1:0] baseline;
	} readout_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_write_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   item_valid = 1'b0;
	logic                   item_ready;
	logic                   kind = KIND_SAMPLE;
	logic [SAMPLE_W-1:0]    raw_sample = '0;
	logic                   scanner_initialising = 1'b0;
	logic                   result_valid;
	logic                   result_ready = 1'b0;
	logic                   led_on;
	logic [DUTY_W-1:0]      duty;
	logic                   touched;
	logic [SAMPLE_W-1:0]    delta_magnitude;
	logic                   delta_negative;
	logic                   baseline_locked;
	logic [SAMPLE_W-1:0]    baseline_value;

	// front-end model state
	int unsigned         fe_learn_sum = 0;
	int unsigned         fe_learn_count = 0;
	logic [SAMPLE_W-1:0] fe_baseline = '0;
	logic                fe_locked = 1'b0;
	logic                fe_touch = 1'b0;
	logic                fe_led = 1'b0;
	logic [DUTY_W-1:0]   fe_duty = '0;
	logic [DUTY_W-1:0]   fe_phase = '0;
	logic [SAMPLE_W-1:0] fe_on_level = TOUCH_ON_RST;
	logic [SAMPLE_W-1:0] fe_off_level = TOUCH_OFF_RST;

	sense_beat_t pending_items[$];
	readout_t    expected_readouts[$];
	sense_beat_t next_beat;

	int  clean_samples_queued = 0;
	int  mismatch_count = 0;
	int  readouts_seen = 0;
	int  send_wait = 0;
	int  recv_wait = 0;
	int  hold_left = 0;
	int  idle_cycles = 0;
	bit  send_steady = 1'b0;
	bit  recv_steady = 1'b0;

	touch_baseline_hysteresis_pwm_top DUT (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic readout_t advance_front_end(logic k, logic [SAMPLE_W-1:0] raw,
			logic init);
		readout_t    r;
		int unsigned mag;
		int unsigned pos;
		logic        neg;
		mag = 0;
		neg = 1'b0;
		if (k == KIND_TICK) begin
			fe_phase = fe_phase + 1'b1;
			fe_led = fe_phase < fe_duty;
		end else begin
			if (!fe_locked && !init) begin
				fe_learn_sum += raw;
				fe_learn_count++;
				if (fe_learn_count >= LEARN_SAMPLES_DEF) begin
					fe_baseline = SAMPLE_W'(fe_learn_sum / fe_learn_count);
					fe_locked = 1'b1;
				end
			end
			if (fe_locked) begin
				if (raw >= fe_baseline) begin
					mag = raw - fe_baseline;
				end else begin
					mag = fe_baseline - raw;
					neg = 1'b1;
				end
				pos = neg ? 0 : mag;
				if (pos > DUTY_SPAN_DEF) begin
					pos = DUTY_SPAN_DEF;
				end
				fe_duty = DUTY_W'((pos * 255) / DUTY_SPAN_DEF);
				if (!fe_touch && !neg && mag >= fe_on_level) begin
					fe_touch = 1'b1;
				end else if (fe_touch && (neg || mag < fe_off_level)) begin
					fe_touch = 1'b0;
				end
			end else begin
				fe_duty = '0;
			end
		end
		r.led      = fe_led;
		r.duty     = fe_duty;
		r.touched  = fe_touch;
		r.mag      = SAMPLE_W'(mag);
		r.neg      = neg;
		r.locked   = fe_locked;
		r.baseline = fe_baseline;
		return r;
	endfunction

	function automatic void queue_item(logic k, logic [SAMPLE_W-1:0] raw, logic init);
		sense_beat_t b;
		b.kind = k;
		b.raw  = raw;
		b.init = init;
		pending_items.push_back(b);
		if (k == KIND_SAMPLE && !init) begin
			clean_samples_queued++;
		end
	endfunction

	function automatic logic [SAMPLE_W-1:0] clamp_raw(int v);
		if (v < 0) begin
			return '0;
		end
		if (v > 65535) begin
			return '1;
		end
		return SAMPLE_W'(v);
	endfunction

	// samples clustered around a mid-scale level until the baseline locks
	function automatic void queue_learning();
		int sel;
		while (clean_samples_queued < LEARN_SAMPLES_DEF) begin
			sel = $urandom_range(0, 99);
			if (sel < 30) begin
				queue_item(KIND_TICK, SAMPLE_W'($urandom), 1'($urandom));
			end else if (sel < 40) begin
				queue_item(KIND_SAMPLE, SAMPLE_W'($urandom), 1'b1);
			end else if (sel < 45) begin
				queue_item(KIND_SAMPLE, SAMPLE_W'($urandom), 1'b0);
			end else begin
				queue_item(KIND_SAMPLE,
					clamp_raw(30000 + int'($urandom_range(0, 4000)) - 2000), 1'b0);
			end
		end
	endfunction

	// deltas aimed at the thresholds, the duty clamp and the negative side
	function automatic void queue_locked_mix(int count);
		int b;
		int sel;
		int offs;
		logic init;
		b = int'(fe_baseline);
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(0, 99);
			init = ($urandom_range(0, 7) == 0);
			if (sel < 30) begin
				queue_item(KIND_TICK, SAMPLE_W'($urandom), 1'($urandom));
			end else if (sel < 90) begin
				case ($urandom_range(0, 3))
					0: offs = int'(fe_on_level) + int'($urandom_range(0, 400)) - 200;
					1: offs = int'(fe_off_level) + int'($urandom_range(0, 400)) - 200;
					2: offs = int'($urandom_range(0, DUTY_SPAN_DEF + 3000));
					default: offs = -int'($urandom_range(0, 5000));
				endcase
				queue_item(KIND_SAMPLE, clamp_raw(b + offs), init);
			end else begin
				queue_item(KIND_SAMPLE, SAMPLE_W'($urandom), init);
			end
		end
	endfunction

	function automatic void check_readout(readout_t got);
		readout_t want;
		if (expected_readouts.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT) begin
				$display("unexpected result beat: duty %0d mag %0d base %0d",
					got.duty, got.mag, got.baseline);
			end
			return;
		end
		want = expected_readouts.pop_front();
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT) begin
				$display("result %0d (expected/actual): led %b/%b duty %0d/%0d touched %b/%b",
					readouts_seen, want.led, got.led, want.duty, got.duty,
					want.touched, got.touched);
				$display("  mag %0d/%0d neg %b/%b locked %b/%b base %0d/%0d",
					want.mag, got.mag, want.neg, got.neg, want.locked, got.locked,
					want.baseline, got.baseline);
			end
		end
	endfunction

	task automatic write_level(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= value;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		if (idx == REG_TOUCH_ON) begin
			fe_on_level = value;
		end else if (idx == REG_TOUCH_OFF) begin
			fe_off_level = value;
		end
	endtask

	task automatic settle();
		@(negedge clk);
		while (pending_items.size() != 0 || item_valid || expected_readouts.size() != 0) begin
			@(negedge clk);
		end
		repeat (PIPE_LATENCY) @(posedge clk);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid           <= 1'b0;
			kind                 <= KIND_SAMPLE;
			raw_sample           <= '0;
			scanner_initialising <= 1'b0;
			send_wait = 0;
		end else begin
			if (item_valid && item_ready) begin
				expected_readouts.push_back(
					advance_front_end(kind, raw_sample, scanner_initialising));
				if ($urandom_range(0, 29) == 0) begin
					send_steady = !send_steady;
				end
				send_wait = send_steady ? 0 : $urandom_range(0, 9);
			end
			if (!item_valid || item_ready) begin
				if (send_wait > 0) begin
					send_wait--;
					item_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					next_beat = pending_items.pop_front();
					item_valid           <= 1'b1;
					kind                 <= next_beat.kind;
					raw_sample           <= next_beat.raw;
					scanner_initialising <= next_beat.init;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			recv_wait = 0;
			hold_left = 0;
		end else begin
			if (result_valid && result_ready) begin
				check_readout({led_on, duty, touched, delta_magnitude, delta_negative,
					baseline_locked, baseline_value});
				readouts_seen++;
				// long back-pressure so the pipeline fills and stalls the input
				if (readouts_seen == HOLD_AT) begin
					hold_left = HOLD_CYCLES;
				end
				if ($urandom_range(0, 29) == 0) begin
					recv_steady = !recv_steady;
				end
				recv_wait = recv_steady ? 0 : $urandom_range(0, 9);
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (recv_wait > 0) begin
				recv_wait--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("touch_baseline_hysteresis_pwm_top: mismatch");
					$finish;
				end
			end
		end
	end

	initial begin
		logic [SAMPLE_W-1:0] on_lv [7];
		logic [SAMPLE_W-1:0] off_lv [7];
		int                  b;
		on_lv[0] = '0;
		off_lv[0] = '0;
		on_lv[1] = '1;
		off_lv[1] = '1;
		on_lv[2] = '1;
		off_lv[2] = '0;
		on_lv[3] = '0;
		off_lv[3] = '1;
		on_lv[4] = SAMPLE_W'(2000);
		off_lv[4] = SAMPLE_W'(800);
		on_lv[5] = SAMPLE_W'($urandom_range(0, 6000));
		off_lv[5] = SAMPLE_W'($urandom_range(0, 6000));
		on_lv[6] = SAMPLE_W'($urandom);
		off_lv[6] = SAMPLE_W'($urandom);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// before lock: ticks, initialising samples and field extremes
		@(negedge clk);
		queue_item(KIND_TICK, '1, 1'b1);
		queue_item(KIND_SAMPLE, '0, 1'b1);
		queue_item(KIND_SAMPLE, '1, 1'b1);
		queue_item(KIND_SAMPLE, '0, 1'b0);
		queue_item(KIND_SAMPLE, '1, 1'b0);
		queue_item(KIND_TICK, '0, 1'b0);
		queue_learning();
		settle();

		// zero delta with a zero on level turns touch on
		write_level(REG_TOUCH_ON, '0);
		write_level(REG_TOUCH_OFF, '0);
		@(negedge clk);
		b = int'(fe_baseline);
		queue_item(KIND_SAMPLE, clamp_raw(b), 1'b0);
		queue_item(KIND_SAMPLE, clamp_raw(b - 1), 1'b0);
		queue_item(KIND_SAMPLE, clamp_raw(b), 1'b1);
		queue_item(KIND_TICK, '0, 1'b0);
		settle();

		// writes past the register list must leave the levels alone
		write_level(REG_TOUCH_ON, TOUCH_ON_RST);
		write_level(REG_TOUCH_OFF, TOUCH_OFF_RST);
		write_level(REG_PAST_END, '0);
		write_level(REG_INDEX_TOP, '0);
		@(negedge clk);
		queue_item(KIND_SAMPLE, clamp_raw(b + DUTY_SPAN_DEF), 1'b0);
		queue_item(KIND_TICK, '0, 1'b0);
		queue_item(KIND_TICK, '1, 1'b1);
		queue_item(KIND_SAMPLE, clamp_raw(b + DUTY_SPAN_DEF + 1), 1'b0);
		queue_item(KIND_SAMPLE, '1, 1'b0);
		queue_item(KIND_SAMPLE, '0, 1'b0);
		queue_item(KIND_SAMPLE, clamp_raw(b + 3000), 1'b0);
		queue_item(KIND_SAMPLE, clamp_raw(b + 1500), 1'b0);
		queue_item(KIND_SAMPLE, clamp_raw(b + 1499), 1'b0);
		settle();

		for (int p = 0; p < 7; p++) begin
			write_level(REG_TOUCH_ON, on_lv[p]);
			write_level(REG_TOUCH_OFF, off_lv[p]);
			@(negedge clk);
			queue_locked_mix(PHASE_ITEMS);
			settle();
		end

		if (mismatch_count == 0) begin
			$display("touch_baseline_hysteresis_pwm_top: match");
		end else begin
			$display("touch_baseline_hysteresis_pwm_top: mismatch");
		end
		$finish;
	end

endmodule
